// ===== rtl/line_pair_closest_points_midpoint_core_macros.svh =====
// Assertion macros shared by the checker of the closest-points core
`ifndef LINE_PAIR_CLOSEST_POINTS_MIDPOINT_CORE_MACROS_SVH
`define LINE_PAIR_CLOSEST_POINTS_MIDPOINT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LPCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpcp check failed");

// next-cycle implication
`define LPCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpcp check failed");

`endif

// ===== rtl/lpcp_pkg.sv =====
// Types and fixed widths of the closest-points core
`timescale 1ns / 1ps
package lpcp_pkg;
	localparam int POS_W    = 32;
	localparam int DIR_W    = 18;
	localparam int CFG_W    = 32;
	localparam int DIFF_W   = POS_W + 1;
	localparam int KPROD_W  = DIFF_W + DIR_W;
	localparam int K_W      = KPROD_W + 2;
	localparam int GPROD_W  = 2 * DIR_W;
	localparam int G_W      = GPROD_W + 2;
	localparam int DMAG_W   = 2 * G_W;
	localparam int DET_W    = DMAG_W + 1;
	localparam int K_LO_W   = 26;
	localparam int K_HI_W   = K_W - K_LO_W;
	localparam int PP_W     = G_W + K_HI_W;
	localparam int NP_W     = G_W + K_W;
	localparam int NUM_W    = NP_W + 1;
	localparam int NMAG_W   = NP_W;
	localparam int QUO_BITS = 33;
	localparam logic [QUO_BITS-1:0] LIM_POS = 33'h0_7FFF_FFFF;
	localparam logic [QUO_BITS-1:0] LIM_NEG = 33'h0_8000_0000;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [DIR_W-1:0] dir_t;
	typedef pos_t [2:0] pos3_t;
	typedef dir_t [2:0] dir3_t;

	typedef struct packed {
		pos3_t pa;
		pos3_t pb;
		dir3_t da;
		dir3_t db;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic par;
		logic neg_a;
		logic neg_b;
	} side_t;

	typedef struct packed {
		logic sat;
		logic [QUO_BITS-1:0] q;
	} quo_t;
endpackage

// ===== rtl/line_pair_closest_points_midpoint_core.sv =====
// Closest points of two 3D lines and their midpoint, fully pipelined
`timescale 1ns / 1ps
// channel  dir  handshake             beat
// in       in   in_valid / in_ready   a_pos_*, a_dir_*, b_pos_*, b_dir_*
// out      out  out_valid / out_ready status, param_*, near_a_*, near_b_*, mid_*
// cfg      in   cfg_valid / cfg_ready cfg_data -> min_determinant
//
// One beat per cycle unless the output stalls; the pipeline has 8 front stages
// (dot products, determinant, numerators), 34 divider stages (saturation test,
// then one quotient bit per stage), 4 back stages (clamp, scale, add, midpoint).
// Reset clears all valid bits and sets min_determinant to 1; cfg_ready is always high.
// A full stage holds while its successor holds; empty stages fill behind a stall.
module line_pair_closest_points_midpoint_core #(
	parameter int DIR_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lpcp_pkg::pos_t       a_pos_x,
	input  lpcp_pkg::pos_t       a_pos_y,
	input  lpcp_pkg::pos_t       a_pos_z,
	input  lpcp_pkg::dir_t       a_dir_x,
	input  lpcp_pkg::dir_t       a_dir_y,
	input  lpcp_pkg::dir_t       a_dir_z,
	input  lpcp_pkg::pos_t       b_pos_x,
	input  lpcp_pkg::pos_t       b_pos_y,
	input  lpcp_pkg::pos_t       b_pos_z,
	input  lpcp_pkg::dir_t       b_dir_x,
	input  lpcp_pkg::dir_t       b_dir_y,
	input  lpcp_pkg::dir_t       b_dir_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output lpcp_pkg::pos_t       param_a,
	output lpcp_pkg::pos_t       param_b,
	output lpcp_pkg::pos_t       near_a_x,
	output lpcp_pkg::pos_t       near_a_y,
	output lpcp_pkg::pos_t       near_a_z,
	output lpcp_pkg::pos_t       near_b_x,
	output lpcp_pkg::pos_t       near_b_y,
	output lpcp_pkg::pos_t       near_b_z,
	output lpcp_pkg::pos_t       mid_x,
	output lpcp_pkg::pos_t       mid_y,
	output lpcp_pkg::pos_t       mid_z,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [lpcp_pkg::CFG_W-1:0] cfg_data
);
	import lpcp_pkg::*;

	localparam int N_W  = NMAG_W + DIR_FRAC_BITS + 2;
	localparam int D2_W = DMAG_W + 1;
	localparam int TH_W = (DMAG_W > CFG_W + 2 * DIR_FRAC_BITS) ? DMAG_W
		: CFG_W + 2 * DIR_FRAC_BITS;
	localparam int TP_W = DIR_W + POS_W;
	localparam int S_W  = TP_W + 2;
	localparam int POS_MAX = 2147483647;
	localparam int POS_MIN = -2147483647 - 1;

	function automatic logic signed [NP_W-1:0] join_pp(logic signed [PP_W-1:0] hi,
			logic signed [PP_W-1:0] lo);
		logic signed [NP_W-1:0] hx;
		hx = NP_W'(hi);
		return (hx <<< K_LO_W) + NP_W'(lo);
	endfunction

	function automatic pos_t sat_param(quo_t x, logic neg);
		logic [QUO_BITS-1:0] lim;
		logic [QUO_BITS-1:0] m;
		lim = neg ? LIM_NEG : LIM_POS;
		m = (x.sat || x.q > lim) ? lim : x.q;
		return neg ? -POS_W'(m) : POS_W'(m);
	endfunction

	// point plus direction*param rounded to POS format, saturated
	function automatic pos_t near_pt(pos_t p, logic signed [TP_W-1:0] prod);
		logic signed [S_W-1:0] r;
		logic signed [S_W-1:0] s;
		r = S_W'(prod) + (S_W'(1) <<< (DIR_FRAC_BITS - 1));
		s = (r >>> DIR_FRAC_BITS) + S_W'(p);
		if (s > S_W'(POS_MAX)) return pos_t'(POS_MAX);
		if (s < S_W'(POS_MIN)) return pos_t'(POS_MIN);
		return POS_W'(s);
	endfunction

	function automatic pos_t mid_pt(pos_t a, pos_t b);
		logic signed [POS_W+1:0] s;
		s = (POS_W + 2)'(a) + (POS_W + 2)'(b) + (POS_W + 2)'(1);
		return s[POS_W:1];
	endfunction

	// configuration
	logic [CFG_W-1:0] min_det_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_det_q <= CFG_W'(1);
		else if (cfg_valid) min_det_q <= cfg_data;
	end

	// stage control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;
	logic adv_s9, adv_s10, adv_s11, adv_s12;
	logic div_in_ready, div_out_valid;

	assign adv_s12 = !v_s12 || out_ready;
	assign adv_s11 = !v_s11 || adv_s12;
	assign adv_s10 = !v_s10 || adv_s11;
	assign adv_s9  = !v_s9  || adv_s10;
	assign adv_s8  = !v_s8  || div_in_ready;
	assign adv_s7  = !v_s7  || adv_s8;
	assign adv_s6  = !v_s6  || adv_s7;
	assign adv_s5  = !v_s5  || adv_s6;
	assign adv_s4  = !v_s4  || adv_s5;
	assign adv_s3  = !v_s3  || adv_s4;
	assign adv_s2  = !v_s2  || adv_s3;
	assign adv_s1  = !v_s1  || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
		end else begin
			if (adv_s1)  v_s1  <= in_valid;
			if (adv_s2)  v_s2  <= v_s1;
			if (adv_s3)  v_s3  <= v_s2;
			if (adv_s4)  v_s4  <= v_s3;
			if (adv_s5)  v_s5  <= v_s4;
			if (adv_s6)  v_s6  <= v_s5;
			if (adv_s7)  v_s7  <= v_s6;
			if (adv_s8)  v_s8  <= v_s7;
			if (adv_s9)  v_s9  <= div_out_valid;
			if (adv_s10) v_s10 <= v_s9;
			if (adv_s11) v_s11 <= v_s10;
			if (adv_s12) v_s12 <= v_s11;
		end
	end

	geo_t geo_in;
	assign geo_in.pa[0] = a_pos_x;
	assign geo_in.pa[1] = a_pos_y;
	assign geo_in.pa[2] = a_pos_z;
	assign geo_in.pb[0] = b_pos_x;
	assign geo_in.pb[1] = b_pos_y;
	assign geo_in.pb[2] = b_pos_z;
	assign geo_in.da[0] = a_dir_x;
	assign geo_in.da[1] = a_dir_y;
	assign geo_in.da[2] = a_dir_z;
	assign geo_in.db[0] = b_dir_x;
	assign geo_in.db[1] = b_dir_y;
	assign geo_in.db[2] = b_dir_z;

	// front datapath
	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7;
	logic signed [DIFF_W-1:0]  diff_s1 [3];
	logic signed [KPROD_W-1:0] kp1_s2 [3];
	logic signed [KPROD_W-1:0] kp2_s2 [3];
	logic signed [GPROD_W-1:0] gab_s2 [3];
	logic signed [GPROD_W-1:0] gaa_s2 [3];
	logic signed [GPROD_W-1:0] gbb_s2 [3];
	logic signed [K_W-1:0]     k1_s3, k2_s3;
	logic signed [G_W-1:0]     a11_s3, aa_s3, bb_s3;
	logic signed [DMAG_W-1:0]  bbaa_s4, a11sq_s4;
	logic signed [PP_W-1:0]    a11k2_hi_s4, a11k2_lo_s4, bbk1_hi_s4, bbk1_lo_s4;
	logic signed [PP_W-1:0]    aak2_hi_s4, aak2_lo_s4, a11k1_hi_s4, a11k1_lo_s4;
	logic signed [DET_W-1:0]   det_s5, det_s6;
	logic signed [NP_W-1:0]    a11k2_s5, bbk1_s5, aak2_s5, a11k1_s5;
	logic signed [NUM_W-1:0]   numa_s6, numb_s6;
	logic [DMAG_W-1:0]         dmag_w, dmag_s7;
	logic [TH_W-1:0]           thr_w;
	logic [NMAG_W-1:0]         nmag_a_s7, nmag_b_s7;
	logic                      neg_a_s7, neg_b_s7, par_s7;
	logic [N_W-1:0]            n_a_s8, n_b_s8;
	logic [D2_W-1:0]           d2_s8;
	side_t                     side_s8;

	assign dmag_w = det_s6[DET_W-1] ? DMAG_W'(-det_s6) : DMAG_W'(det_s6);
	assign thr_w  = TH_W'(min_det_q) << (2 * DIR_FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			geo_s1 <= geo_in;
			for (int i = 0; i < 3; i++)
				diff_s1[i] <= DIFF_W'($signed(geo_in.pa[i])) - DIFF_W'($signed(geo_in.pb[i]));
		end
		if (adv_s2 && v_s1) begin
			geo_s2 <= geo_s1;
			for (int i = 0; i < 3; i++) begin
				kp1_s2[i] <= diff_s1[i] * $signed(geo_s1.da[i]);
				kp2_s2[i] <= diff_s1[i] * $signed(geo_s1.db[i]);
				gab_s2[i] <= $signed(geo_s1.da[i]) * $signed(geo_s1.db[i]);
				gaa_s2[i] <= $signed(geo_s1.da[i]) * $signed(geo_s1.da[i]);
				gbb_s2[i] <= $signed(geo_s1.db[i]) * $signed(geo_s1.db[i]);
			end
		end
		if (adv_s3 && v_s2) begin
			geo_s3 <= geo_s2;
			k1_s3  <= K_W'(kp1_s2[0]) + K_W'(kp1_s2[1]) + K_W'(kp1_s2[2]);
			k2_s3  <= K_W'(kp2_s2[0]) + K_W'(kp2_s2[1]) + K_W'(kp2_s2[2]);
			a11_s3 <= G_W'(gab_s2[0]) + G_W'(gab_s2[1]) + G_W'(gab_s2[2]);
			aa_s3  <= G_W'(gaa_s2[0]) + G_W'(gaa_s2[1]) + G_W'(gaa_s2[2]);
			bb_s3  <= G_W'(gbb_s2[0]) + G_W'(gbb_s2[1]) + G_W'(gbb_s2[2]);
		end
		// wide numerator products split at K_LO_W into two partial products
		if (adv_s4 && v_s3) begin
			geo_s4      <= geo_s3;
			bbaa_s4     <= bb_s3 * aa_s3;
			a11sq_s4    <= a11_s3 * a11_s3;
			a11k2_hi_s4 <= a11_s3 * $signed(k2_s3[K_W-1:K_LO_W]);
			a11k2_lo_s4 <= a11_s3 * $signed({1'b0, k2_s3[K_LO_W-1:0]});
			bbk1_hi_s4  <= bb_s3 * $signed(k1_s3[K_W-1:K_LO_W]);
			bbk1_lo_s4  <= bb_s3 * $signed({1'b0, k1_s3[K_LO_W-1:0]});
			aak2_hi_s4  <= aa_s3 * $signed(k2_s3[K_W-1:K_LO_W]);
			aak2_lo_s4  <= aa_s3 * $signed({1'b0, k2_s3[K_LO_W-1:0]});
			a11k1_hi_s4 <= a11_s3 * $signed(k1_s3[K_W-1:K_LO_W]);
			a11k1_lo_s4 <= a11_s3 * $signed({1'b0, k1_s3[K_LO_W-1:0]});
		end
		if (adv_s5 && v_s4) begin
			geo_s5   <= geo_s4;
			det_s5   <= DET_W'(bbaa_s4) - DET_W'(a11sq_s4);
			a11k2_s5 <= join_pp(a11k2_hi_s4, a11k2_lo_s4);
			bbk1_s5  <= join_pp(bbk1_hi_s4, bbk1_lo_s4);
			aak2_s5  <= join_pp(aak2_hi_s4, aak2_lo_s4);
			a11k1_s5 <= join_pp(a11k1_hi_s4, a11k1_lo_s4);
		end
		if (adv_s6 && v_s5) begin
			geo_s6  <= geo_s5;
			det_s6  <= det_s5;
			numa_s6 <= NUM_W'(a11k2_s5) - NUM_W'(bbk1_s5);
			numb_s6 <= NUM_W'(aak2_s5) - NUM_W'(a11k1_s5);
		end
		if (adv_s7 && v_s6) begin
			geo_s7    <= geo_s6;
			dmag_s7   <= dmag_w;
			par_s7    <= (dmag_w == '0) || (TH_W'(dmag_w) < thr_w);
			nmag_a_s7 <= numa_s6[NUM_W-1] ? NMAG_W'(-numa_s6) : NMAG_W'(numa_s6);
			nmag_b_s7 <= numb_s6[NUM_W-1] ? NMAG_W'(-numb_s6) : NMAG_W'(numb_s6);
			neg_a_s7  <= (numa_s6[NUM_W-1] ^ det_s6[DET_W-1]) && (numa_s6 != '0);
			neg_b_s7  <= (numb_s6[NUM_W-1] ^ det_s6[DET_W-1]) && (numb_s6 != '0);
		end
		// rounded quotient: (2*|num|*2^F + |D|) / (2*|D|)
		if (adv_s8 && v_s7) begin
			n_a_s8        <= (N_W'(nmag_a_s7) << (DIR_FRAC_BITS + 1)) + N_W'(dmag_s7);
			n_b_s8        <= (N_W'(nmag_b_s7) << (DIR_FRAC_BITS + 1)) + N_W'(dmag_s7);
			d2_s8         <= {dmag_s7, 1'b0};
			side_s8.geo   <= geo_s7;
			side_s8.par   <= par_s7;
			side_s8.neg_a <= neg_a_s7;
			side_s8.neg_b <= neg_b_s7;
		end
	end

	quo_t  div_quo_a, div_quo_b;
	side_t div_side;

	lpcp_div #(
		.N_W (N_W),
		.D_W (D2_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.in_ready  (div_in_ready),
		.num_a     (n_a_s8),
		.num_b     (n_b_s8),
		.den       (d2_s8),
		.side_in   (side_s8),
		.out_valid (div_out_valid),
		.out_ready (adv_s9),
		.quo_a     (div_quo_a),
		.quo_b     (div_quo_b),
		.side_out  (div_side)
	);

	// back datapath
	geo_t geo_s9, geo_s10;
	logic par_s9, par_s10, par_s11;
	pos_t ta_s9, tb_s9, ta_s10, tb_s10, ta_s11, tb_s11;
	logic signed [TP_W-1:0] prod_a_s10 [3];
	logic signed [TP_W-1:0] prod_b_s10 [3];
	pos_t near_a_s11 [3];
	pos_t near_b_s11 [3];
	logic status_s12;
	pos_t param_a_s12, param_b_s12;
	pos_t near_a_s12 [3];
	pos_t near_b_s12 [3];
	pos_t mid_s12 [3];

	always_ff @(posedge clk) begin
		if (adv_s9 && div_out_valid) begin
			geo_s9 <= div_side.geo;
			par_s9 <= div_side.par;
			ta_s9  <= sat_param(div_quo_a, div_side.neg_a);
			tb_s9  <= sat_param(div_quo_b, div_side.neg_b);
		end
		if (adv_s10 && v_s9) begin
			geo_s10 <= geo_s9;
			par_s10 <= par_s9;
			ta_s10  <= ta_s9;
			tb_s10  <= tb_s9;
			for (int i = 0; i < 3; i++) begin
				prod_a_s10[i] <= $signed(geo_s9.da[i]) * ta_s9;
				prod_b_s10[i] <= $signed(geo_s9.db[i]) * tb_s9;
			end
		end
		if (adv_s11 && v_s10) begin
			par_s11 <= par_s10;
			ta_s11  <= ta_s10;
			tb_s11  <= tb_s10;
			for (int i = 0; i < 3; i++) begin
				near_a_s11[i] <= near_pt($signed(geo_s10.pa[i]), prod_a_s10[i]);
				near_b_s11[i] <= near_pt($signed(geo_s10.pb[i]), prod_b_s10[i]);
			end
		end
		// parallel lines give status 1 and zeros elsewhere
		if (adv_s12 && v_s11) begin
			status_s12  <= par_s11;
			param_a_s12 <= par_s11 ? '0 : ta_s11;
			param_b_s12 <= par_s11 ? '0 : tb_s11;
			for (int i = 0; i < 3; i++) begin
				near_a_s12[i] <= par_s11 ? '0 : near_a_s11[i];
				near_b_s12[i] <= par_s11 ? '0 : near_b_s11[i];
				mid_s12[i]    <= par_s11 ? '0 : mid_pt(near_a_s11[i], near_b_s11[i]);
			end
		end
	end

	assign out_valid = v_s12;
	assign status    = status_s12;
	assign param_a   = param_a_s12;
	assign param_b   = param_b_s12;
	assign near_a_x  = near_a_s12[0];
	assign near_a_y  = near_a_s12[1];
	assign near_a_z  = near_a_s12[2];
	assign near_b_x  = near_b_s12[0];
	assign near_b_y  = near_b_s12[1];
	assign near_b_z  = near_b_s12[2];
	assign mid_x     = mid_s12[0];
	assign mid_y     = mid_s12[1];
	assign mid_z     = mid_s12[2];
endmodule

// ===== rtl/lpcp_div.sv =====
// Pipelined restoring divider, two numerators over one divisor, one quotient bit a stage
`timescale 1ns / 1ps
module lpcp_div #(
	parameter int N_W = 108,
	parameter int D_W = 77
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [N_W-1:0]       num_a,
	input  logic [N_W-1:0]       num_b,
	input  logic [D_W-1:0]       den,
	input  lpcp_pkg::side_t      side_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lpcp_pkg::quo_t       quo_a,
	output lpcp_pkg::quo_t       quo_b,
	output lpcp_pkg::side_t      side_out
);
	import lpcp_pkg::*;

	localparam int NST = QUO_BITS + 1;
	localparam int C_W = (N_W > D_W + QUO_BITS) ? N_W : D_W + QUO_BITS;

	logic           v_s [NST];
	logic [NST:0]   adv;
	logic [N_W-1:0] rem_a_s [NST];
	logic [N_W-1:0] rem_b_s [NST];
	logic [D_W-1:0] den_s [NST];
	quo_t           quo_a_s [NST];
	quo_t           quo_b_s [NST];
	side_t          side_s [NST];

	logic [C_W-1:0] dsh [QUO_BITS];
	logic           take_a [QUO_BITS];
	logic           take_b [QUO_BITS];

	// a stage moves when it is empty or its successor moves
	always_comb begin
		adv[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--) adv[k] = !v_s[k] || adv[k+1];
	end

	always_comb begin
		for (int j = 0; j < QUO_BITS; j++) begin
			dsh[j]    = C_W'(den_s[j]) << (QUO_BITS - 1 - j);
			take_a[j] = C_W'(rem_a_s[j]) >= dsh[j];
			take_b[j] = C_W'(rem_b_s[j]) >= dsh[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) v_s[k] <= 1'b0;
		end else begin
			if (adv[0]) v_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) if (adv[k]) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		// first stage: quotient of 2^33 or more saturates
		if (adv[0] && in_valid) begin
			rem_a_s[0]     <= num_a;
			rem_b_s[0]     <= num_b;
			den_s[0]       <= den;
			side_s[0]      <= side_in;
			quo_a_s[0].sat <= C_W'(num_a) >= (C_W'(den) << QUO_BITS);
			quo_b_s[0].sat <= C_W'(num_b) >= (C_W'(den) << QUO_BITS);
			quo_a_s[0].q   <= '0;
			quo_b_s[0].q   <= '0;
		end
		for (int j = 0; j < QUO_BITS; j++) begin
			if (adv[j+1] && v_s[j]) begin
				rem_a_s[j+1] <= take_a[j] ? N_W'(C_W'(rem_a_s[j]) - dsh[j]) : rem_a_s[j];
				rem_b_s[j+1] <= take_b[j] ? N_W'(C_W'(rem_b_s[j]) - dsh[j]) : rem_b_s[j];
				den_s[j+1]   <= den_s[j];
				side_s[j+1]  <= side_s[j];
				quo_a_s[j+1].sat <= quo_a_s[j].sat;
				quo_b_s[j+1].sat <= quo_b_s[j].sat;
				quo_a_s[j+1].q <= quo_a_s[j].q
					| (QUO_BITS'(take_a[j]) << (QUO_BITS - 1 - j));
				quo_b_s[j+1].q <= quo_b_s[j].q
					| (QUO_BITS'(take_b[j]) << (QUO_BITS - 1 - j));
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_s[NST-1];
	assign quo_a     = quo_a_s[NST-1];
	assign quo_b     = quo_b_s[NST-1];
	assign side_out  = side_s[NST-1];
endmodule

// ===== rtl/lpcp_checker.sv =====
// Port-level checks of the closest-points core, bound to its top level
`timescale 1ns / 1ps
`include "line_pair_closest_points_midpoint_core_macros.svh"
module lpcp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               status,
	input logic signed [31:0] param_a,
	input logic signed [31:0] param_b,
	input logic signed [31:0] near_a_x,
	input logic signed [31:0] near_b_x,
	input logic signed [31:0] mid_x
);
	logic signed [33:0] sum_x;
	logic signed [31:0] mid_ref_x;

	assign sum_x     = 34'(near_a_x) + 34'(near_b_x) + 34'sd1;
	assign mid_ref_x = sum_x[32:1];

	`LPCP_ASSERT_NOW(a_par_zero, out_valid && status, param_a == 0 && param_b == 0 && near_a_x == 0 && near_b_x == 0 && mid_x == 0)
	`LPCP_ASSERT_NOW(a_mid_x, out_valid && !status, mid_x == mid_ref_x)
	// input backpressure only when every stage is full behind a stalled output
	`LPCP_ASSERT_NOW(a_backpressure, !in_ready, out_valid && !out_ready)
	`LPCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mid_x) && $stable(status))
endmodule

bind line_pair_closest_points_midpoint_core lpcp_checker u_lpcp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking bench for the closest-points core: line pairs in, checked against a local predictor
`timescale 1ns / 1ps
module testbench;
	import lpcp_pkg::*;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic  status;
		pos_t  ta;
		pos_t  tb;
		pos3_t na;
		pos3_t nb;
		pos3_t mid;
	} closest_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	pos_t a_pos_x = 0, a_pos_y = 0, a_pos_z = 0, b_pos_x = 0, b_pos_y = 0, b_pos_z = 0;
	dir_t a_dir_x = 0, a_dir_y = 0, a_dir_z = 0, b_dir_x = 0, b_dir_y = 0, b_dir_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic status;
	pos_t param_a, param_b, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z;
	pos_t mid_x, mid_y, mid_z;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = 0;

	geo_t     line_pairs[$];
	closest_t closest_due[$];
	logic [31:0] min_det = 1;
	bit quiet = 0;
	int errors = 0;
	int got = 0;
	bit held_off = 0;

	line_pair_closest_points_midpoint_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_pos_x(a_pos_x), .a_pos_y(a_pos_y), .a_pos_z(a_pos_z),
		.a_dir_x(a_dir_x), .a_dir_y(a_dir_y), .a_dir_z(a_dir_z),
		.b_pos_x(b_pos_x), .b_pos_y(b_pos_y), .b_pos_z(b_pos_z),
		.b_dir_x(b_dir_x), .b_dir_y(b_dir_y), .b_dir_z(b_dir_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .param_a(param_a), .param_b(param_b),
		.near_a_x(near_a_x), .near_a_y(near_a_y), .near_a_z(near_a_z),
		.near_b_x(near_b_x), .near_b_y(near_b_y), .near_b_z(near_b_z),
		.mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic wide_t round_shift(wide_t v, int s);
		return (v + (wide_t'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic wide_t clamp32(wide_t v);
		wide_t hi;
		hi = (wide_t'(1) <<< 31) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// num * 2^16 / den, half away from zero, saturated
	function automatic wide_t line_param(wide_t num, wide_t den);
		wide_t n, d, q, lim;
		logic neg;
		neg = ((num < 0) != (den < 0)) && (num != 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = ((n <<< 17) + d) / (d <<< 1);
		lim = neg ? (wide_t'(1) <<< 31) : (wide_t'(1) <<< 31) - 1;
		if (q > lim) q = lim;
		return neg ? -q : q;
	endfunction

	function automatic closest_t closest_pair(geo_t g, logic [31:0] thr_reg);
		closest_t r;
		wide_t d, k1, k2, a11, aa, bb, det, thr, num_a, num_b, ta, tb, na, nb;
		r = '0;
		k1 = 0; k2 = 0; a11 = 0; aa = 0; bb = 0;
		for (int i = 0; i < 3; i++) begin
			d = $signed(g.pa[i]) - $signed(g.pb[i]);
			k1 += d * $signed(g.da[i]);
			k2 += d * $signed(g.db[i]);
			a11 += $signed(g.da[i]) * $signed(g.db[i]);
			aa += $signed(g.da[i]) * $signed(g.da[i]);
			bb += $signed(g.db[i]) * $signed(g.db[i]);
		end
		det = bb * aa - a11 * a11;
		thr = 0;
		thr[63:32] = thr_reg;
		if (det == 0 || ((det < 0) ? -det : det) < thr) begin
			r.status = 1'b1;
			return r;
		end
		num_a = a11 * k2 - bb * k1;
		num_b = k2 * aa - k1 * a11;
		ta = line_param(num_a, det);
		tb = line_param(num_b, det);
		r.ta = ta[31:0];
		r.tb = tb[31:0];
		for (int i = 0; i < 3; i++) begin
			na = clamp32($signed(g.pa[i]) + round_shift($signed(g.da[i]) * ta, 16));
			nb = clamp32($signed(g.pb[i]) + round_shift($signed(g.db[i]) * tb, 16));
			r.na[i] = na[31:0];
			r.nb[i] = nb[31:0];
			r.mid[i] = pos_t'(round_shift(na + nb, 1));
		end
		return r;
	endfunction

	function automatic dir_t rand_dir();
		return dir_t'($urandom_range(0, 131072)) - dir_t'(65536);
	endfunction

	function automatic pos_t rand_pos(bit wide_range);
		if (wide_range) return pos_t'($urandom);
		return pos_t'($urandom_range(0, 1 << 23)) - pos_t'(1 << 22);
	endfunction

	function automatic geo_t rand_pair();
		geo_t g;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			g.pa[i] = rand_pos(mode >= 6 || $urandom_range(0, 7) == 0);
			g.pb[i] = rand_pos(mode >= 6 || $urandom_range(0, 7) == 0);
			g.da[i] = (mode == 6) ? dir_t'($urandom) : rand_dir();
			g.db[i] = (mode == 6) ? dir_t'($urandom) : rand_dir();
		end
		for (int i = 0; i < 3; i++) begin
			if (mode == 7) g.db[i] = g.da[i];
			if (mode == 8) g.db[i] = -g.da[i];
			// near parallel pushes the parameters into saturation
			if (mode == 9) g.db[i] = g.da[i] + dir_t'($urandom_range(0, 6)) - dir_t'(3);
		end
		return g;
	endfunction

	function automatic geo_t mk(pos_t ax, pos_t ay, pos_t az, dir_t dax, dir_t day, dir_t daz,
		pos_t bx, pos_t by, pos_t bz, dir_t dbx, dir_t dby, dir_t dbz);
		geo_t g;
		g.pa[0] = ax; g.pa[1] = ay; g.pa[2] = az;
		g.da[0] = dax; g.da[1] = day; g.da[2] = daz;
		g.pb[0] = bx; g.pb[1] = by; g.pb[2] = bz;
		g.db[0] = dbx; g.db[1] = dby; g.db[2] = dbz;
		return g;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic wait_drained();
		while (line_pairs.size() != 0 || closest_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_min_det(logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		min_det = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				closest_due.push_back(closest_pair(line_pairs.pop_front(), min_det));
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					in_gap = $urandom_range(1, 12) - 1;
					in_valid <= 1'b0;
				end else if (line_pairs.size() > 0) begin
					in_valid <= 1'b1;
					a_pos_x <= line_pairs[0].pa[0];
					a_pos_y <= line_pairs[0].pa[1];
					a_pos_z <= line_pairs[0].pa[2];
					a_dir_x <= line_pairs[0].da[0];
					a_dir_y <= line_pairs[0].da[1];
					a_dir_z <= line_pairs[0].da[2];
					b_pos_x <= line_pairs[0].pb[0];
					b_pos_y <= line_pairs[0].pb[1];
					b_pos_z <= line_pairs[0].pb[2];
					b_dir_x <= line_pairs[0].db[0];
					b_dir_y <= line_pairs[0].db[1];
					b_dir_z <= line_pairs[0].db[2];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int out_gap = 0;
	int hold = 0;
	always @(posedge clk) begin
		closest_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got++;
				if (closest_due.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = closest_due.pop_front();
					check_field("status", 32'(e.status), 32'(status));
					check_field("param_a", e.ta, param_a);
					check_field("param_b", e.tb, param_b);
					check_field("near_a_x", e.na[0], near_a_x);
					check_field("near_a_y", e.na[1], near_a_y);
					check_field("near_a_z", e.na[2], near_a_z);
					check_field("near_b_x", e.nb[0], near_b_x);
					check_field("near_b_y", e.nb[1], near_b_y);
					check_field("near_b_z", e.nb[2], near_b_z);
					check_field("mid_x", e.mid[0], mid_x);
					check_field("mid_y", e.mid[1], mid_y);
					check_field("mid_z", e.mid[2], mid_z);
				end
			end
			// one long back-pressure stretch to fill the pipeline
			if (!held_off && got == 120) begin
				held_off = 1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		logic [31:0] settings[6];
		settings[0] = 32'd0;
		settings[1] = 32'hFFFF_FFFF;
		settings[2] = $urandom;
		settings[3] = 32'd16;
		settings[4] = $urandom_range(0, 4096);
		settings[5] = 32'd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: reset threshold of 1
		line_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		line_pairs.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 0, 32'sh10000, 0, 65536, 0));
		line_pairs.push_back(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 65536, 65536, 65536,
			32'sh80000000, 32'sh80000000, 32'sh80000000, -65536, 65536, 0));
		line_pairs.push_back(mk(32'sh80000000, 0, 32'sh7FFFFFFF, -65536, -65536, 0,
			32'sh7FFFFFFF, 32'sh80000000, 0, 0, 65536, -65536));
		line_pairs.push_back(mk(100, 200, 300, 65536, 0, 0, 5, 6, 7, 65536, 0, 0));
		line_pairs.push_back(mk(100, 200, 300, 65536, 65536, 0, 5, 6, 7, -65536, -65536, 0));
		line_pairs.push_back(mk(1, 2, 3, 18'sh1FFFF, 18'sh1FFFF, 18'sh20000,
			4, 5, 6, 18'sh20000, 18'sh1FFFF, 18'sh1FFFF));
		line_pairs.push_back(mk(1, 2, 3, 18'sh1FFFF, 0, 0, 4, 5, 6, 18'sh20000, 1, 0));
		line_pairs.push_back(mk(32'sh7FFFFFFF, 0, 0, 65536, 0, 0,
			32'sh80000000, 0, 32'sh100000, 65536, 1, 0));
		line_pairs.push_back(mk(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0));
		line_pairs.push_back(mk(0, 0, 0, 2, 0, 0, 65536, 0, 0, 0, 2, 0));
		line_pairs.push_back(mk(32'sh00018000, 32'shFFFE8000, 0, 65536, 0, 0,
			0, 0, 32'sh00008000, 0, 65536, 0));
		line_pairs.push_back(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 65536, 0, 0,
			0, 0, 0, 0, 65536, 0));
		line_pairs.push_back(mk(-3, -3, -3, 0, 0, 65536, 3, 3, 3, 65536, 65536, 65536));
		for (int i = 0; i < 10; i++) line_pairs.push_back(rand_pair());
		wait_drained();
		for (int p = 0; p < 6; p++) begin
			write_min_det(settings[p]);
			@(negedge clk);
			if (p == 5) quiet = 1;
			for (int i = 0; i < 150; i++) line_pairs.push_back(rand_pair());
			wait_drained();
		end
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/lpcp_pkg.sv
rtl/lpcp_div.sv
rtl/line_pair_closest_points_midpoint_core.sv
rtl/lpcp_checker.sv
tb/testbench.sv
